>>> sv/hcsp_pkg.sv
// Package for the hex color spec parser.
// Types and constants shared by all modules, and the hex digit decoder used by the front end. No dependencies.
`timescale 1ns / 1ps

package hcsp_pkg;

    localparam logic [7:0] HASH_CHAR  = 8'h23;
    localparam logic [3:0] MAX_DIGITS = 4'd12;
    localparam logic [3:0] COUNT_SAT  = 4'd13;
    localparam int         BUF_BITS   = 48;
    localparam int         COMP_BITS  = 16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_HASH   = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BAD_DIGIT = 2'd3
    } status_t;

    // one finished spec, handed from the front end to the formatter
    typedef struct packed {
        logic [BUF_BITS-1:0] nibbles;
        logic [3:0]          count;
        logic                no_hash;
        logic                bad_digit;
    } job_t;

    // bit 4 set: not a hex digit; low nibble then zero
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'h10;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res = {1'b0, ch[3:0]};
        end
        else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
        begin
            // 'A'-'F' and 'a'-'f' share low bits 1..6
            res = {1'b0, ch[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage

>>> sv/hcsp_front.sv
// Front end of the hex color spec parser: per-character prefix check, digit decode
// and nibble collection. Emits one job per spec. Depends on hcsp_pkg.
`timescale 1ns / 1ps

module hcsp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          char_valid,
    input  logic [7:0]    char_code,
    input  logic          is_last,
    output logic          job_push,
    output hcsp_pkg::job_t job
);
    import hcsp_pkg::*;

    logic [BUF_BITS-1:0] nib_reg, nib_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                first_reg, first_next;
    logic                nohash_reg, nohash_next;
    logic                derr_reg, derr_next;

    logic [BUF_BITS-1:0] nib_upd;
    logic [3:0]          cnt_upd;
    logic                nohash_upd;
    logic                derr_upd;
    logic [4:0]          dec;

    always_comb
    begin
        dec        = hex_decode(char_code);
        nib_upd    = nib_reg;
        cnt_upd    = cnt_reg;
        nohash_upd = nohash_reg;
        derr_upd   = derr_reg;
        if (first_reg)
        begin
            nohash_upd = (char_code != HASH_CHAR);
        end
        else if (!nohash_reg)
        begin
            if (dec[4])
            begin
                derr_upd = 1'b1;
            end
            if (cnt_reg < MAX_DIGITS)
            begin
                nib_upd = {nib_reg[BUF_BITS-5:0], dec[3:0]};
            end
            if (cnt_reg < COUNT_SAT)
            begin
                cnt_upd = cnt_reg + 4'd1;
            end
        end

        job.nibbles   = nib_upd;
        job.count     = cnt_upd;
        job.no_hash   = nohash_upd;
        job.bad_digit = derr_upd;
        job_push      = char_valid && is_last;

        nib_next    = nib_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        nohash_next = nohash_reg;
        derr_next   = derr_reg;
        if (char_valid)
        begin
            if (is_last)
            begin
                // spec done: back to the start-of-spec state
                nib_next    = '0;
                cnt_next    = '0;
                first_next  = 1'b1;
                nohash_next = 1'b0;
                derr_next   = 1'b0;
            end
            else
            begin
                nib_next    = nib_upd;
                cnt_next    = cnt_upd;
                first_next  = 1'b0;
                nohash_next = nohash_upd;
                derr_next   = derr_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_reg    <= '0;
            cnt_reg    <= '0;
            first_reg  <= 1'b1;
            nohash_reg <= 1'b0;
            derr_reg   <= 1'b0;
        end
        else
        begin
            nib_reg    <= nib_next;
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
            nohash_reg <= nohash_next;
            derr_reg   <= derr_next;
        end
    end

endmodule

>>> sv/hcsp_job_fifo.sv
// Short job queue between the front end and the formatter.
// Holds finished specs; depth set by the top level. Depends on hcsp_pkg.
`timescale 1ns / 1ps

module hcsp_job_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hcsp_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output hcsp_pkg::job_t pop_data
);
    import hcsp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    always_comb
    begin
        full     = (cnt_reg == FULL_CNT);
        empty    = (cnt_reg == '0);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_data = mem_reg[rd_reg];
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("job queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("job queue lost a push");

endmodule

>>> sv/hcsp_back.sv
// Formatter of the hex color spec parser: status priority, group split and
// left alignment, into the result register. Depends on hcsp_pkg.
`timescale 1ns / 1ps

module hcsp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_avail,
    input  hcsp_pkg::job_t job,
    output logic           job_take,
    input  logic           pop,
    output logic           empty,
    output logic [1:0]     status,
    output logic [15:0]    red,
    output logic [15:0]    green,
    output logic [15:0]    blue
);
    import hcsp_pkg::*;

    logic          valid_reg, valid_next;
    status_t       st_reg, st_next;
    logic [15:0]   r_reg, r_next;
    logic [15:0]   g_reg, g_next;
    logic [15:0]   b_reg, b_next;
    logic          load;

    always_comb
    begin
        load   = job_avail && (!valid_reg || pop);
        r_next = '0;
        g_next = '0;
        b_next = '0;
        st_next = ST_OK;
        if (job.no_hash)
        begin
            st_next = ST_NO_HASH;
        end
        else if (job.count != 4'd3 && job.count != 4'd6 &&
                 job.count != 4'd9 && job.count != 4'd12)
        begin
            st_next = ST_BAD_LEN;
        end
        else if (job.bad_digit)
        begin
            st_next = ST_BAD_DIGIT;
        end
        else
        begin
            unique case (job.count)
                4'd3:
                begin
                    r_next = {job.nibbles[11:8], 12'd0};
                    g_next = {job.nibbles[7:4], 12'd0};
                    b_next = {job.nibbles[3:0], 12'd0};
                end
                4'd6:
                begin
                    r_next = {job.nibbles[23:16], 8'd0};
                    g_next = {job.nibbles[15:8], 8'd0};
                    b_next = {job.nibbles[7:0], 8'd0};
                end
                4'd9:
                begin
                    r_next = {job.nibbles[35:24], 4'd0};
                    g_next = {job.nibbles[23:12], 4'd0};
                    b_next = {job.nibbles[11:0], 4'd0};
                end
                default:
                begin
                    r_next = job.nibbles[47:32];
                    g_next = job.nibbles[31:16];
                    b_next = job.nibbles[15:0];
                end
            endcase
        end

        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end

        job_take = load;
        empty    = !valid_reg;
        status   = st_reg;
        red      = r_reg;
        green    = g_reg;
        blue     = b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_reg <= st_next;
            r_reg  <= r_next;
            g_reg  <= g_next;
            b_reg  <= b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && st_reg != ST_OK) |-> (r_reg == '0 && g_reg == '0 && b_reg == '0))
        else $error("error result carries color data");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !pop) |=> (valid_reg && $stable(r_reg) && $stable(st_reg)))
        else $error("result changed before transfer");

endmodule

>>> sv/hex_color_spec_parser.sv
// Top level of the hex color spec parser: front end, job queue and formatter.
// Depends on hcsp_pkg, hcsp_front, hcsp_job_fifo, hcsp_back.
`timescale 1ns / 1ps

// Parses "#" followed by 3, 6, 9 or 12 hex digits, one character per transfer,
// is_last marking the end of a spec. One character is taken every cycle while
// full is low; a finished spec passes through the job queue and then the
// result register before its result appears. full rises only when the
// JOB_DEPTH-entry job queue holds finished specs that the result side has not
// drained; non-hex, missing-prefix and bad-length specs return status codes
// with zero color fields.
module hex_color_spec_parser #(
    parameter int JOB_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue
);
    import hcsp_pkg::*;

    logic char_valid;
    logic job_push;
    job_t job_in;
    job_t job_out;
    logic job_empty;
    logic job_take;

    assign char_valid = push && !full;

    hcsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_code  (char_code),
        .is_last    (is_last),
        .job_push   (job_push),
        .job        (job_in)
    );

    hcsp_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (full),
        .pop       (job_take),
        .empty     (job_empty),
        .pop_data  (job_out)
    );

    hcsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!job_empty),
        .job       (job_out),
        .job_take  (job_take),
        .pop       (pop),
        .empty     (empty),
        .status    (status),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule
